### design/hmpk_pkg.sv
`timescale 1ns / 1ps

package hmpk_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF   = 512;
	localparam int SAMPLE_BITS_DEF = 16;

	// Row and column counters are 9 bits wide
	localparam int COUNT_BITS  = 9;
	localparam int COUNT_LIMIT = 512;

	// Configuration port
	localparam int SIZE_BITS  = 10;
	localparam int THR_BITS   = 16;
	localparam int CFG_BITS   = 16;
	localparam int INDEX_BITS = 2;

	localparam logic [INDEX_BITS-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_PEAK_THRESHOLD = 2'd2;

	localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RST  = 10'd368;
	localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RST = 10'd368;
	localparam logic [THR_BITS-1:0]  THRESHOLD_RST    = 16'd2048;  // 0.5 in Q3.12

	localparam logic [SIZE_BITS-1:0] SIZE_MIN = 10'd3;

endpackage

### design/hmpk_ram.sv
`timescale 1ns / 1ps

module hmpk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/heatmap_local_peak_detect.sv
`timescale 1ns / 1ps

// 3x3 local peak detector for a raster-order heatmap stream. One sample is
// taken every clock unless a new peak meets an earlier one that the result
// side has not taken yet. An accepted sample is registered in the input
// register while both line stores are read at its column; while it waits
// there the 3x3 compare runs, and when it leaves, the line stores and the
// window are updated and a peak (if any) is loaded into the result register.
// The decision for pixel (row r, column c) is reached while pixel (r+1, c+1)
// sits in the input register and is offered once that sample leaves it.
// The rate is set by the single read and single write per cycle on each
// line-store memory. Border pixels never report. Line stores hold no reset
// state; frame_width, frame_height and peak_threshold may only be written
// while the block is idle.
module heatmap_local_peak_detect #(
	parameter int MAX_WIDTH   = hmpk_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = hmpk_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hmpk_pkg::INDEX_BITS-1:0]   cfg_index,
	input  logic [hmpk_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample_value,
	output logic                              peak_valid,
	input  logic                              peak_ready,
	output logic [hmpk_pkg::COUNT_BITS-1:0]   peak_column,
	output logic [hmpk_pkg::COUNT_BITS-1:0]   peak_row
);

	localparam int LINE_DEPTH = (MAX_WIDTH < hmpk_pkg::COUNT_LIMIT) ?
		MAX_WIDTH : hmpk_pkg::COUNT_LIMIT;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CMP_BITS = (SAMPLE_BITS > hmpk_pkg::THR_BITS) ?
		SAMPLE_BITS : hmpk_pkg::THR_BITS;
	localparam int SB = hmpk_pkg::SIZE_BITS;
	localparam int CB = hmpk_pkg::COUNT_BITS;

	typedef logic signed [CMP_BITS-1:0] cmp_t;

	// Configuration registers
	logic [SB-1:0]                      fw_q, fh_q;
	logic [hmpk_pkg::THR_BITS-1:0]      thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= hmpk_pkg::FRAME_WIDTH_RST;
			fh_q  <= hmpk_pkg::FRAME_HEIGHT_RST;
			thr_q <= hmpk_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmpk_pkg::REG_FRAME_WIDTH:    fw_q  <= cfg_data[SB-1:0];
				hmpk_pkg::REG_FRAME_HEIGHT:   fh_q  <= cfg_data[SB-1:0];
				hmpk_pkg::REG_PEAK_THRESHOLD: thr_q <= cfg_data[hmpk_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size
	logic [SB-1:0] w_eff, h_eff;

	always_comb begin
		if (fw_q < hmpk_pkg::SIZE_MIN) begin
			w_eff = hmpk_pkg::SIZE_MIN;
		end else if (fw_q > SB'(LINE_DEPTH)) begin
			w_eff = SB'(LINE_DEPTH);
		end else begin
			w_eff = fw_q;
		end
		if (fh_q < hmpk_pkg::SIZE_MIN) begin
			h_eff = hmpk_pkg::SIZE_MIN;
		end else if (fh_q > SB'(hmpk_pkg::COUNT_LIMIT)) begin
			h_eff = SB'(hmpk_pkg::COUNT_LIMIT);
		end else begin
			h_eff = fh_q;
		end
	end

	// Position counters
	logic [CB-1:0] col_q, row_q;
	logic [SB-1:0] c_cur, r_cur, c_nxt, r_nxt;

	always_comb begin
		c_cur = {1'b0, col_q};
		r_cur = {1'b0, row_q};
		// wrap a stale position first
		if (c_cur >= w_eff) begin
			c_cur = '0;
			r_cur = r_cur + SB'(1);
		end
		if (r_cur >= h_eff) begin
			r_cur = '0;
		end
		c_nxt = c_cur + SB'(1);
		r_nxt = r_cur;
		if (c_nxt >= w_eff) begin
			c_nxt = '0;
			r_nxt = r_cur + SB'(1);
			if (r_nxt >= h_eff) begin
				r_nxt = '0;
			end
		end
	end

	// Stage 1: sample register, line stores are being read
	logic                          vld_s1;
	logic                          inner_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [CB-1:0]                 col_s1, row_s1;
	logic                          accept, adv;
	logic                          is_peak;

	// a non-peak item passes even while an earlier peak waits
	assign adv          = vld_s1 && (!is_peak || !peak_valid || peak_ready);
	assign sample_ready = !vld_s1 || adv;
	assign accept       = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				col_q  <= c_nxt[CB-1:0];
				row_q  <= r_nxt[CB-1:0];
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1   <= sample_value;
			col_s1   <= c_cur[CB-1:0];
			row_s1   <= r_cur[CB-1:0];
			inner_s1 <= (c_cur >= SB'(2)) && (r_cur >= SB'(2));
		end
	end

	// Line stores: read on accept, written when the item leaves stage 1
	logic signed [SAMPLE_BITS-1:0] up_rd, mid_rd;

	hmpk_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (LINE_DEPTH)
	) u_upper (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1[AW-1:0]),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (c_cur[AW-1:0]),
		.rdata (up_rd)
	);

	hmpk_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (LINE_DEPTH)
	) u_middle (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1[AW-1:0]),
		.wdata (smp_s1),
		.re    (accept),
		.raddr (c_cur[AW-1:0]),
		.rdata (mid_rd)
	);

	// Window: [0..2] column c-2, [3..5] column c-1, rows r-2, r-1, r
	logic signed [SAMPLE_BITS-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= smp_s1;
		end
	end

	// Strict-maximum test of the window center, also against the threshold
	cmp_t ctr;

	assign ctr = cmp_t'(win_q[4]);

	always_comb begin
		is_peak = inner_s1
			&& (ctr > cmp_t'(win_q[0])) && (ctr > cmp_t'(win_q[1]))
			&& (ctr > cmp_t'(win_q[2])) && (ctr > cmp_t'(win_q[3]))
			&& (ctr > cmp_t'(win_q[5])) && (ctr > cmp_t'(up_rd))
			&& (ctr > cmp_t'(mid_rd))   && (ctr > cmp_t'(smp_s1))
			&& (ctr > cmp_t'($signed(thr_q)));
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_valid <= 1'b0;
		end else if (adv && is_peak) begin
			peak_valid <= 1'b1;
		end else if (peak_ready) begin
			peak_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_peak) begin
			peak_column <= col_s1 - CB'(1);
			peak_row    <= row_s1 - CB'(1);
		end
	end

	// A reported peak is never on the top row or left column
	a_peak_interior: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid |-> (peak_column != '0) && (peak_row != '0))
		else $error("peak reported on frame border");

	// A stalled stage-1 item holds its position
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage 1 item lost while stalled");

	// A new result comes only from a stage-1 item
	a_peak_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(peak_valid) |-> $past(vld_s1))
		else $error("result without a sample behind it");

	// An empty stage 1 always takes a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> sample_ready)
		else $error("input stalled with empty stage 1");

endmodule

### sim/heatmap_peak_checker.sv
`timescale 1ns / 1ps

module heatmap_peak_checker
	import hmpk_pkg::*;
(
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [INDEX_BITS-1:0]             cfg_index,
	input  logic [CFG_BITS-1:0]               cfg_data,
	input  logic                              sample_valid,
	input  logic                              sample_ready,
	input  logic signed [SAMPLE_BITS_DEF-1:0] sample_value,
	input  logic                              peak_valid,
	input  logic                              peak_ready,
	input  logic [COUNT_BITS-1:0]             peak_column,
	input  logic [COUNT_BITS-1:0]             peak_row,
	output int                                mismatch_count,
	output int                                peaks_pending
);

	localparam int WIDTH_HI = (MAX_WIDTH_DEF < COUNT_LIMIT) ? MAX_WIDTH_DEF : COUNT_LIMIT;

	typedef struct packed {
		logic [COUNT_BITS-1:0] column;
		logic [COUNT_BITS-1:0] row;
	} peak_pos_t;

	peak_pos_t                         expected_peaks[$];
	logic [SIZE_BITS-1:0]              width_reg;
	logic [SIZE_BITS-1:0]              height_reg;
	logic signed [THR_BITS-1:0]        threshold_reg;
	logic signed [SAMPLE_BITS_DEF-1:0] upper_line [WIDTH_HI];
	logic signed [SAMPLE_BITS_DEF-1:0] middle_line [WIDTH_HI];
	// columns c-2 and c-1, each top to bottom
	logic signed [SAMPLE_BITS_DEF-1:0] nbhd [6];
	int                                next_col;
	int                                next_row;

	function automatic int eff_size(logic [SIZE_BITS-1:0] raw, int hi);
		if (raw < SIZE_MIN)
			return SIZE_MIN;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	task automatic clear_state();
		width_reg = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		threshold_reg = THRESHOLD_RST;
		for (int i = 0; i < WIDTH_HI; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			nbhd[i] = '0;
		next_col = 0;
		next_row = 0;
		expected_peaks.delete();
	endtask

	task automatic predict_peak(input logic signed [SAMPLE_BITS_DEF-1:0] s);
		int c, r, w, h;
		logic signed [SAMPLE_BITS_DEF-1:0] up, mid, ctr;
		peak_pos_t hit;
		w = eff_size(width_reg, WIDTH_HI);
		h = eff_size(height_reg, COUNT_LIMIT);
		c = next_col;
		r = next_row;
		// counters left beyond a shrunk frame start a new row or frame first
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
		up = upper_line[c];
		mid = middle_line[c];
		if (r >= 2 && c >= 2) begin
			ctr = nbhd[4];
			if (ctr > nbhd[0] && ctr > nbhd[1] && ctr > nbhd[2] && ctr > nbhd[3] &&
			    ctr > nbhd[5] && ctr > up && ctr > mid && ctr > s && ctr > threshold_reg) begin
				hit.column = COUNT_BITS'(c - 1);
				hit.row = COUNT_BITS'(r - 1);
				expected_peaks.insert(expected_peaks.size(), hit);
			end
		end
		upper_line[c] = mid;
		middle_line[c] = s;
		nbhd[0] = nbhd[3];
		nbhd[1] = nbhd[4];
		nbhd[2] = nbhd[5];
		nbhd[3] = up;
		nbhd[4] = mid;
		nbhd[5] = s;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_col = c;
		next_row = r;
	endtask

	task automatic check_peak();
		peak_pos_t want;
		if (expected_peaks.size() == 0) begin
			$error("unexpected peak at column %0d row %0d", peak_column, peak_row);
			mismatch_count++;
		end else begin
			want = expected_peaks.pop_front();
			if (peak_column !== want.column) begin
				$error("peak_column: expected %0d, actual %0d", want.column, peak_column);
				mismatch_count++;
			end
			if (peak_row !== want.row) begin
				$error("peak_row: expected %0d, actual %0d", want.row, peak_row);
				mismatch_count++;
			end
		end
	endtask

	initial begin
		mismatch_count = 0;
		peaks_pending = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:    width_reg = cfg_data[SIZE_BITS-1:0];
					REG_FRAME_HEIGHT:   height_reg = cfg_data[SIZE_BITS-1:0];
					REG_PEAK_THRESHOLD: threshold_reg = cfg_data[THR_BITS-1:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready)
				predict_peak(sample_value);
			if (peak_valid && peak_ready)
				check_peak();
		end
		peaks_pending = expected_peaks.size();
	end

endmodule

### sim/heatmap_local_peak_detect_test.sv
`timescale 1ns / 1ps

module heatmap_local_peak_detect_test;
	import hmpk_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 300;
	localparam int DRAIN_CYCLES    = 6;
	localparam int WIDTH_HI = (MAX_WIDTH_DEF < COUNT_LIMIT) ? MAX_WIDTH_DEF : COUNT_LIMIT;

	localparam logic [INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		SRC_FULL,
		SRC_NEAR_THR,
		SRC_SPIKY,
		SRC_EXTREME,
		SRC_LATTICE
	} sample_src_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [INDEX_BITS-1:0]             cfg_index = '0;
	logic [CFG_BITS-1:0]               cfg_data = '0;
	logic                              sample_valid = 1'b0;
	logic                              sample_ready;
	logic signed [SAMPLE_BITS_DEF-1:0] sample_value = '0;
	logic                              peak_valid;
	logic                              peak_ready = 1'b0;
	logic [COUNT_BITS-1:0]             peak_column;
	logic [COUNT_BITS-1:0]             peak_row;

	int mismatch_count;
	int peaks_pending;
	int cycle_count = 0;

	// raster position and line-store fill as seen from the stimulus side
	logic [SIZE_BITS-1:0]       width_raw = FRAME_WIDTH_RST;
	logic [SIZE_BITS-1:0]       height_raw = FRAME_HEIGHT_RST;
	logic signed [THR_BITS-1:0] thr_now = THRESHOLD_RST;
	int                         pos_col = 0;
	int                         pos_row = 0;
	bit                         up_ok [WIDTH_HI];
	bit                         mid_ok [WIDTH_HI];

	bit no_gaps = 1'b0;
	bit hold_off_req = 1'b0;
	int stall_left = 0;
	int burst_left = 0;
	int accept_pct = 100;

	always #6 clk = ~clk;

	heatmap_local_peak_detect i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_value (sample_value),
		.peak_valid   (peak_valid),
		.peak_ready   (peak_ready),
		.peak_column  (peak_column),
		.peak_row     (peak_row)
	);

	heatmap_peak_checker i_peak_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample_value   (sample_value),
		.peak_valid     (peak_valid),
		.peak_ready     (peak_ready),
		.peak_column    (peak_column),
		.peak_row       (peak_row),
		.mismatch_count (mismatch_count),
		.peaks_pending  (peaks_pending)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			peak_ready <= 1'b0;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			stall_left = HOLD_OFF_CYCLES - 1;
			peak_ready <= 1'b0;
		end else begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(16, 96);
				case ($urandom_range(0, 4))
					0, 1: accept_pct = 100;
					2:    accept_pct = 85;
					3:    accept_pct = 40;
					default: begin
						accept_pct = 100;
						stall_left = $urandom_range(10, 40);
					end
				endcase
			end
			burst_left--;
			peak_ready <= ($urandom_range(1, 100) <= accept_pct);
		end
	end

	function automatic int eff_size(logic [SIZE_BITS-1:0] raw, int hi);
		if (raw < SIZE_MIN)
			return SIZE_MIN;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// a width is safe when every column it covers holds written line data
	function automatic bit width_safe(int w);
		for (int c = 0; c < w; c++)
			if (!up_ok[c] || !mid_ok[c])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [SAMPLE_BITS_DEF-1:0] draw_sample(sample_src_t src);
		int k, v;
		k = $urandom_range(0, 3);
		case (src)
			SRC_FULL:
				return 16'($urandom());
			SRC_NEAR_THR: begin
				// plateaus around the threshold exercise the strict compares
				v = int'(thr_now) + k - 1;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				return 16'(v);
			end
			SRC_SPIKY: begin
				if (k == 0)
					return 16'($urandom_range(4096, 32767));
				v = $urandom_range(0, 4096);
				return 16'(v - 2048);
			end
			SRC_EXTREME: begin
				case (k)
					0:       return 16'sh8000;
					1:       return 16'sh7FFF;
					2:       return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: begin
				// one peak per 2x2 block: the densest output the block can make
				if (pos_row % 2 == 1 && pos_col % 2 == 1)
					return 16'(12000 + int'($urandom_range(0, 255)));
				v = $urandom_range(0, 1000);
				return 16'(-v);
			end
		endcase
	endfunction

	task automatic align_position();
		if (pos_col >= eff_size(width_raw, WIDTH_HI)) begin
			pos_col = 0;
			pos_row++;
		end
		if (pos_row >= eff_size(height_raw, COUNT_LIMIT))
			pos_row = 0;
	endtask

	task automatic write_reg(input logic [INDEX_BITS-1:0] index, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		case (index)
			REG_FRAME_WIDTH:    width_raw = data[SIZE_BITS-1:0];
			REG_FRAME_HEIGHT:   height_raw = data[SIZE_BITS-1:0];
			REG_PEAK_THRESHOLD: thr_now = data[THR_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop the request, drain all peaks and let the pipeline settle
	task automatic quiesce();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (peaks_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
	                              input logic [CFG_BITS-1:0] t);
		quiesce();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_PEAK_THRESHOLD, t);
	endtask

	task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] v);
		int gap;
		align_position();
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_value <= v;
		do
			@(posedge clk);
		while (!sample_ready);
		up_ok[pos_col] = mid_ok[pos_col];
		mid_ok[pos_col] = 1'b1;
		pos_col++;
		if (pos_col >= eff_size(width_raw, WIDTH_HI)) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= eff_size(height_raw, COUNT_LIMIT))
				pos_row = 0;
		end
	endtask

	task automatic push_random(input sample_src_t src);
		align_position();
		push_sample(draw_sample(src));
	endtask

	initial begin
		int          random_sent;
		int          n;
		int          new_w;
		int          new_h;
		int          new_t;
		sample_src_t src;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_UNUSED, 16'hFFFF);

		// smallest frame: center at the top of the range fails a maximal threshold
		apply_settings(16'd3, 16'd3, 16'h7FFF);
		for (int i = 0; i < 9; i++)
			push_sample(i == 4 ? 16'sh7FFF : 16'sh8000);
		// one step lower and the same center becomes a peak
		apply_settings(16'd3, 16'd3, 16'h7FFE);
		for (int i = 0; i < 9; i++)
			push_sample(i == 4 ? 16'sh7FFF : 16'sh8000);
		// lowest threshold, center one above the floor
		apply_settings(16'd3, 16'd3, 16'h8000);
		for (int i = 0; i < 9; i++)
			push_sample(i == 4 ? 16'sh8001 : 16'sh8000);

		// hold off the result side while dense peaks keep coming
		apply_settings(16'd8, 16'd8, 16'd0);
		no_gaps = 1'b1;
		hold_off_req = 1'b1;
		repeat (128) push_random(SRC_LATTICE);
		no_gaps = 1'b0;

		// widest frame, oversize write saturates; run well into the third row
		apply_settings(16'd1023, 16'd2, 16'd2048);
		repeat (2 * WIDTH_HI + 300) push_random(SRC_FULL);

		// tall frame, then shrink the height mid-frame
		apply_settings(16'd3, 16'd1023, 16'h4000);
		repeat (3 * 40 + 1) push_random(SRC_SPIKY);
		apply_settings(16'd3, 16'd4, 16'd2048);
		repeat (12) push_random(SRC_NEAR_THR);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       new_w = $urandom_range(0, 2);
				1:       new_w = $urandom_range(13, 40);
				default: new_w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0:       new_h = $urandom_range(0, 2);
				1:       new_h = $urandom_range(9, 20);
				default: new_h = $urandom_range(3, 8);
			endcase
			case ($urandom_range(0, 2))
				0:       new_t = $urandom();
				1:       new_t = $urandom_range(0, 4096);
				default: new_t = 2048;
			endcase
			// keep the width unless the raster is at its start or every column it reads already holds data
			if (!((pos_col == 0 && pos_row == 0) ||
			      width_safe(eff_size(SIZE_BITS'(new_w), WIDTH_HI))))
				new_w = width_raw;
			apply_settings(16'(new_w), 16'(new_h), 16'(new_t));
			src = sample_src_t'($urandom_range(0, 4));
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				do begin
					push_random(src);
					random_sent++;
				end while (pos_col != 0 || pos_row != 0);
			end else begin
				n = $urandom_range(1, eff_size(width_raw, WIDTH_HI) *
				                      eff_size(height_raw, COUNT_LIMIT));
				repeat (n) push_random(src);
				random_sent += n;
			end
		end
		no_gaps = 1'b0;

		quiesce();
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### sim.f
design/hmpk_pkg.sv
design/hmpk_ram.sv
design/heatmap_local_peak_detect.sv
sim/heatmap_peak_checker.sv
sim/heatmap_local_peak_detect_test.sv
